// File: design/psfr_pkg.sv
// Shared types and constants for the particle sensor frame receiver.
package psfr_pkg;

  localparam logic [7:0]  START_FIRST   = 8'h42;
  localparam logic [7:0]  START_SECOND  = 8'h4D;
  localparam logic [15:0] FRAME_LENGTH  = 16'd28;
  localparam logic [4:0]  PAYLOAD_BYTES = 5'd26;
  localparam int          STORE_WORDS   = 13;
  localparam logic [3:0]  WORD_VERSION  = 4'd12;
  localparam logic [3:0]  WORD_ERROR    = 4'd13;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SECOND,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY,
    PH_DRAIN
  } phase_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sum_init;
    logic sum_add;
    logic hold_hi;
    logic clr_pos;
    logic adv_pos;
    logic store_byte;
    logic drain_start;
    logic emit_word;
    logic emit_err;
  } psfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_first;
    logic is_second;
    logic length_ok;
    logic cks_ok;
    logic pos_in_payload;
    logic pos_at_cks_hi;
    logic word_last;
    logic out_free;
  } psfr_stat_t;

endpackage

// File: design/psfr_rx_if.sv
// Input channel: received byte or receive-timeout event.
interface psfr_rx_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

// File: design/psfr_res_if.sv
// Output channel: one measurement word or one checksum error result.
interface psfr_res_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [3:0]  word_index;
  logic [15:0] value;
  logic        last;

  modport source (output valid, output status, output word_index, output value,
                  output last, input ready);
  modport sink   (input valid, input status, input word_index, input value,
                  input last, output ready);
endinterface

// File: design/psfr_ctrl.sv
// Frame sync and result drain controller.
module psfr_ctrl
  import psfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  input  logic       rx_action_i,
  output logic       rx_ready_o,
  input  psfr_stat_t stat_i,
  output psfr_cmd_t  cmd_o
);

  phase_e state_q, state_d;
  logic   receiving;
  logic   fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PH_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    receiving  = (state_q != PH_DRAIN);
    rx_ready_o = receiving && stat_i.out_free;
    fire       = rx_valid_i && rx_ready_o;

    if (fire && rx_action_i) begin
      // Timeout: drop the current frame.
      state_d = PH_HUNT;
    end else if (fire) begin
      case (state_q)
        PH_SECOND: begin
          if (stat_i.is_second) begin
            cmd_o.sum_add = 1'b1;
            state_d       = PH_LEN_HI;
          end else if (stat_i.is_first) begin
            cmd_o.sum_init = 1'b1;
            state_d        = PH_SECOND;
          end else begin
            state_d = PH_HUNT;
          end
        end
        PH_LEN_HI: begin
          cmd_o.hold_hi = 1'b1;
          cmd_o.sum_add = 1'b1;
          state_d       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (stat_i.length_ok) begin
            cmd_o.sum_add = 1'b1;
            cmd_o.clr_pos = 1'b1;
            state_d       = PH_BODY;
          end else begin
            state_d = PH_HUNT;
          end
        end
        PH_BODY: begin
          if (stat_i.pos_in_payload) begin
            cmd_o.store_byte = 1'b1;
            cmd_o.sum_add    = 1'b1;
            cmd_o.adv_pos    = 1'b1;
          end else if (stat_i.pos_at_cks_hi) begin
            cmd_o.hold_hi = 1'b1;
            cmd_o.adv_pos = 1'b1;
          end else if (stat_i.cks_ok) begin
            cmd_o.drain_start = 1'b1;
            state_d           = PH_DRAIN;
          end else begin
            cmd_o.emit_err = 1'b1;
            state_d        = PH_HUNT;
          end
        end
        default: begin
          if (stat_i.is_first) begin
            cmd_o.sum_init = 1'b1;
            state_d        = PH_SECOND;
          end else begin
            state_d = PH_HUNT;
          end
        end
      endcase
    end else if (state_q == PH_DRAIN && stat_i.out_free) begin
      cmd_o.emit_word = 1'b1;
      if (stat_i.word_last) begin
        state_d = PH_HUNT;
      end
    end
  end

endmodule

// File: design/psfr_datapath.sv
// Sum, length and checksum checks, payload store and result register.
module psfr_datapath
  import psfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  rx_byte_i,
  input  psfr_cmd_t   cmd_i,
  output psfr_stat_t  stat_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        out_status_o,
  output logic [3:0]  out_word_index_o,
  output logic [15:0] out_value_o,
  output logic        out_last_o
);

  logic [4:0]  pos_q;
  logic [15:0] sum_q;
  logic [7:0]  held_hi_q;
  logic [7:0]  pay_hi_q;
  logic [3:0]  widx_q, widx_d;
  logic [3:0]  rd_addr;
  logic [15:0] rd_data_q;
  logic [15:0] store_mem [STORE_WORDS];

  logic        out_valid_q;
  logic        out_status_q;
  logic [3:0]  out_index_q;
  logic [15:0] out_value_q;
  logic        out_last_q;
  logic [15:0] word_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      widx_q <= '0;
    end else begin
      if (cmd_i.sum_init) begin
        sum_q <= {8'h00, START_FIRST};
      end else if (cmd_i.sum_add) begin
        sum_q <= sum_q + {8'h00, rx_byte_i};
      end
      if (cmd_i.clr_pos || cmd_i.sum_init) begin
        pos_q <= '0;
      end else if (cmd_i.adv_pos) begin
        pos_q <= pos_q + 5'd1;
      end
      widx_q <= widx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_hi) begin
      held_hi_q <= rx_byte_i;
    end
    if (cmd_i.store_byte && !pos_q[0]) begin
      pay_hi_q <= rx_byte_i;
    end
  end

  // Pack byte pairs into words; odd positions complete a word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte && pos_q[0]) begin
      store_mem[pos_q[4:1]] <= {pay_hi_q, rx_byte_i};
    end
    rd_data_q <= store_mem[rd_addr];
  end

  // Read ahead at the next word index so data is ready when the word goes out.
  always_comb begin
    widx_d = widx_q;
    if (cmd_i.drain_start) begin
      widx_d = '0;
    end else if (cmd_i.emit_word) begin
      widx_d = widx_q + 4'd1;
    end
    rd_addr = (widx_d >= WORD_VERSION) ? WORD_VERSION : widx_d;
  end

  always_comb begin
    if (widx_q == WORD_VERSION) begin
      word_value = {8'h00, rd_data_q[15:8]};
    end else if (widx_q == WORD_ERROR) begin
      word_value = {8'h00, rd_data_q[7:0]};
    end else begin
      word_value = rd_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_word || cmd_i.emit_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_word) begin
      out_status_q <= 1'b0;
      out_index_q  <= widx_q;
      out_value_q  <= word_value;
      out_last_q   <= (widx_q == WORD_ERROR);
    end else if (cmd_i.emit_err) begin
      out_status_q <= 1'b1;
      out_index_q  <= '0;
      out_value_q  <= '0;
      out_last_q   <= 1'b1;
    end
  end

  always_comb begin
    stat_o.is_first       = (rx_byte_i == START_FIRST);
    stat_o.is_second      = (rx_byte_i == START_SECOND);
    stat_o.length_ok      = ({held_hi_q, rx_byte_i} == FRAME_LENGTH);
    stat_o.cks_ok         = ({held_hi_q, rx_byte_i} == sum_q);
    stat_o.pos_in_payload = (pos_q < PAYLOAD_BYTES);
    stat_o.pos_at_cks_hi  = (pos_q == PAYLOAD_BYTES);
    stat_o.word_last      = (widx_q == WORD_ERROR);
    stat_o.out_free       = !out_valid_q || out_ready_i;
  end

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_word_index_o = out_index_q;
  assign out_value_o      = out_value_q;
  assign out_last_o       = out_last_q;

  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit_word && cmd_i.emit_err))
    else $error("word and error result loaded together");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(cmd_i.emit_word || cmd_i.emit_err))
    else $error("stalled result overwritten");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_status_q || out_index_q == WORD_ERROR))
    else $error("last flag on a word other than the error code");

  a_drain_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_word |-> (widx_q <= WORD_ERROR))
    else $error("drain ran past the final word");

endmodule

// File: design/particle_sensor_frame_receiver.sv
// Top level of the particle sensor frame receiver.
//
// rx_i takes one item per received serial byte (action 0) or a receive
// timeout (action 1, which drops the frame in progress). The block hunts for
// 0x42 0x4D, checks the length field is 28, sums bytes 0 to 29 and compares
// the sum with the trailing checksum.
// res_o gives, for a good frame, 14 items: twelve readings, the version byte
// and the sensor error byte, the last one marked. A bad checksum gives one
// item with status 1. Bad length or timeout gives nothing.
// Timing: after the checksum byte of a good frame, rx_i stays not ready while
// the 14 words drain at one per cycle, when res_o does not stall, from the
// 13-word payload store through the result register. The store's registered
// read port is addressed one word ahead.
// rx_i is also not ready while a result waits in the result register and
// res_o is not ready; a stalled receiver holds the drain at the current word.
// Reset: returns to hunting with the result register empty; the payload store
// keeps its contents and needs no clearing pass.
module particle_sensor_frame_receiver
  import psfr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  psfr_rx_if.sink   rx_i,
  psfr_res_if.source res_o
);

  psfr_cmd_t  cmd;
  psfr_stat_t stat;

  // Control: frame phase and drain sequencing.
  psfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_i.valid),
    .rx_action_i (rx_i.action),
    .rx_ready_o  (rx_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: sum, checks, store and result register.
  psfr_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_byte_i        (rx_i.rx_byte),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (res_o.ready),
    .out_valid_o      (res_o.valid),
    .out_status_o     (res_o.status),
    .out_word_index_o (res_o.word_index),
    .out_value_o      (res_o.value),
    .out_last_o       (res_o.last)
  );

endmodule
